### rtl/bit_parallel_edit_distance_top_assert.svh
// Assertion macros for the bit-parallel edit distance block.
// Included by the RTL files that check their own logic; needs no package.
`ifndef BIT_PARALLEL_EDIT_DISTANCE_TOP_ASSERT_SVH
`define BIT_PARALLEL_EDIT_DISTANCE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Condition that holds on the same edge as its trigger.
`define BPED_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Condition that holds on the edge after its trigger.
`define BPED_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
// Invariant checked on every edge out of reset.
`define BPED_ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`else
`define BPED_ASSERT_NOW(lbl, clk, rst, ante, cons, msg)
`define BPED_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`define BPED_ASSERT_ALWAYS(lbl, clk, rst, cond, msg)
`endif
`endif

### rtl/bped_pkg.sv
// Shared types and constants for the bit-parallel edit distance block.
// No dependencies; imported by bped_cell and the top level.
package bped_pkg;

  localparam int WORD_BITS   = 64;
  localparam int ROW_W       = 6;
  localparam int SYMBOL_BITS = 16;
  localparam int SCORE_BITS  = 16;
  localparam logic [SCORE_BITS-1:0] SCORE_MAX = '1;

  typedef enum logic [1:0] {
    MODE_LOAD   = 2'd0,
    MODE_WORD   = 2'd1,
    MODE_FINISH = 2'd2
  } mode_t;

  // One word symbol travelling down the chain with its horizontal carry.
  typedef struct packed {
    logic                   valid;
    logic [SYMBOL_BITS-1:0] sym;
    logic                   p;
    logic                   m;
  } tok_t;

  // Score change reported by the cell that holds the last reference row.
  typedef struct packed {
    logic up;
    logic down;
  } evt_t;

endpackage

### rtl/bit_parallel_edit_distance_top.sv
// Top level of the bit-parallel edit distance block: reference loading,
// score keeping and the result register. Depends on bped_pkg, bped_cell
// and bit_parallel_edit_distance_top_assert.svh.
//
//   channel | signals                          | direction
//   --------+----------------------------------+----------
//   in      | in_valid, in_stall, mode, symbol | into block
//   out     | out_valid, out_stall, distance,  | out of block
//           | reference_overflow               |
//
// Load and word beats are taken one per cycle. A word beat enters the cell
// chain in the cycle after acceptance and moves one cell per cycle, since the
// horizontal carry of one 64-row block feeds the next; it leaves the chain
// at the cell that holds the last reference row. A finish beat waits until
// the chain is empty and the result register is free. rst is synchronous and
// clears the round state; the reference symbol store itself is not cleared.
module bit_parallel_edit_distance_top
  import bped_pkg::*;
#(
  parameter int PATTERN_WORDS = 4
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [1:0]             mode,
  input  logic [SYMBOL_BITS-1:0] symbol,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [SCORE_BITS-1:0]  distance,
  output logic                   reference_overflow
);

`include "bit_parallel_edit_distance_top_assert.svh"

  localparam int CAPACITY = PATTERN_WORDS * WORD_BITS;
  localparam int LEN_W    = $clog2(CAPACITY + 1);
  localparam int BLK_W    = LEN_W - ROW_W;

  // round state
  logic [LEN_W-1:0]      ref_len;
  logic [SCORE_BITS-1:0] score;
  logic                  word_started;
  logic                  overflow_seen;
  tok_t                  tok0;

  // carry chain: entry 0 is the injection register, entry b+1 leaves cell b
  tok_t                  tok_chain [PATTERN_WORDS+1];
  evt_t                  evt       [PATTERN_WORDS];
  logic [PATTERN_WORDS-1:0] evt_any;
  logic [PATTERN_WORDS:0]   tok_busy_vec;
  logic                  tok_busy;
  logic                  score_up, score_down;

  logic in_acc, acc_load, acc_word, acc_finish, store_ok;
  logic [PATTERN_WORDS-1:0] load_en;

  assign in_acc = in_valid && !in_stall;

  always_comb begin
    acc_load   = 1'b0;
    acc_word   = 1'b0;
    acc_finish = 1'b0;
    case (mode_t'(mode))
      MODE_LOAD:   acc_load   = in_acc;
      MODE_WORD:   acc_word   = in_acc;
      MODE_FINISH: acc_finish = in_acc;
      default: ;
    endcase
  end

  // hold a finish beat until the chain drains and the result slot is free
  assign in_stall = (mode_t'(mode) == MODE_FINISH) && (tok_busy || (out_valid && out_stall));

  assign store_ok = acc_load && !word_started && (ref_len < LEN_W'(CAPACITY));

  assign tok_chain[0] = tok0;

  genvar b;
  generate
    for (b = 0; b < PATTERN_WORDS; b++) begin : g_cell
      assign load_en[b] = store_ok && (ref_len[LEN_W-1:ROW_W] == BLK_W'(b));
      assign evt_any[b] = evt[b].up || evt[b].down;

      bped_cell #(
        .CELL_INDEX(b),
        .LEN_W     (LEN_W)
      ) u_cell (
        .clk     (clk),
        .rst     (rst),
        .clear   (acc_finish),
        .load_en (load_en[b]),
        .load_row(ref_len[ROW_W-1:0]),
        .load_sym(symbol),
        .ref_len (ref_len),
        .tok_in  (tok_chain[b]),
        .tok_out (tok_chain[b+1]),
        .evt     (evt[b])
      );
    end
    for (b = 0; b <= PATTERN_WORDS; b++) begin : g_busy
      assign tok_busy_vec[b] = tok_chain[b].valid;
    end
  endgenerate

  assign tok_busy = |tok_busy_vec;

  always_comb begin
    score_up   = 1'b0;
    score_down = 1'b0;
    for (int i = 0; i < PATTERN_WORDS; i++) begin
      score_up   = score_up   | evt[i].up;
      score_down = score_down | evt[i].down;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || acc_finish) begin
      ref_len       <= '0;
      score         <= '0;
      word_started  <= 1'b0;
      overflow_seen <= 1'b0;
      tok0          <= '0;
    end else begin
      if (store_ok) begin
        ref_len <= ref_len + LEN_W'(1);
      end else if (acc_load && !word_started) begin
        overflow_seen <= 1'b1;
      end

      // capacity is far below the score ceiling, so the length never saturates
      if (acc_word && !word_started) begin
        word_started <= 1'b1;
        if (ref_len == '0) begin
          score <= SCORE_BITS'(1);
        end else begin
          score <= SCORE_BITS'(ref_len);
        end
      end else if (acc_word && ref_len == '0) begin
        if (score != SCORE_MAX) begin
          score <= score + SCORE_BITS'(1);
        end
      end else if (score_up) begin
        if (score != SCORE_MAX) begin
          score <= score + SCORE_BITS'(1);
        end
      end else if (score_down) begin
        // sticky at the ceiling, floor at zero
        if (score != SCORE_MAX && score != '0) begin
          score <= score - SCORE_BITS'(1);
        end
      end

      tok0.valid <= acc_word && (ref_len != '0);
      tok0.sym   <= symbol;
      tok0.p     <= 1'b1;
      tok0.m     <= 1'b0;
    end
  end

  // result register: fill on finish, drop once the beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (acc_finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_finish) begin
      distance           <= word_started ? score : SCORE_BITS'(ref_len);
      reference_overflow <= overflow_seen;
    end
  end

  `BPED_ASSERT_ALWAYS(a_one_last_cell, clk, rst, $onehot0(evt_any),
    "score event from more than one cell")
  `BPED_ASSERT_NOW(a_busy_has_word, clk, rst, tok_busy, word_started,
    "carry in flight outside a word")
  `BPED_ASSERT_NEXT(a_finish_result, clk, rst, acc_finish,
    out_valid && ref_len == '0 && !word_started && !overflow_seen,
    "finish did not present a result and clear the round")
  `BPED_ASSERT_NOW(a_finish_drained, clk, rst, acc_finish, !tok_busy && !evt_any[0],
    "finish accepted while the chain was busy")

endmodule

### rtl/bped_cell.sv
// One 64-row block of the reference: symbols, vertical delta vectors and
// the Myers column step. Depends on bped_pkg.
module bped_cell
  import bped_pkg::*;
#(
  parameter int CELL_INDEX = 0,
  parameter int LEN_W      = 9
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   clear,
  input  logic                   load_en,
  input  logic [ROW_W-1:0]       load_row,
  input  logic [SYMBOL_BITS-1:0] load_sym,
  input  logic [LEN_W-1:0]       ref_len,
  input  tok_t                   tok_in,
  output tok_t                   tok_out,
  output evt_t                   evt
);

  localparam int BLK_W = LEN_W - ROW_W;
  localparam logic [BLK_W-1:0] IDX = BLK_W'(CELL_INDEX);

  logic [SYMBOL_BITS-1:0] ref_sym [WORD_BITS];
  logic [WORD_BITS-1:0]   pv, mv;

  logic [LEN_W-1:0]     len_m1;
  logic                 is_last;
  logic [ROW_W-1:0]     top_bit;
  logic [WORD_BITS-1:0] row_mask, eq, eqm, xv, xh, ph, mh, phs, mhs;
  logic [WORD_BITS-1:0] pv_next, mv_next;
  logic                 p_out, m_out;

  always_comb begin
    len_m1  = ref_len - LEN_W'(1);
    is_last = (ref_len != '0) && (len_m1[LEN_W-1:ROW_W] == IDX);
    top_bit = is_last ? len_m1[ROW_W-1:0] : ROW_W'(WORD_BITS - 1);
    if (ref_len[LEN_W-1:ROW_W] > IDX) begin
      row_mask = '1;
    end else if (ref_len[LEN_W-1:ROW_W] == IDX) begin
      row_mask = ~({WORD_BITS{1'b1}} << ref_len[ROW_W-1:0]);
    end else begin
      row_mask = '0;
    end
    for (int i = 0; i < WORD_BITS; i++) begin
      eq[i] = row_mask[i] && (ref_sym[i] == tok_in.sym);
    end
    xv    = eq | mv;
    eqm   = eq | {{(WORD_BITS-1){1'b0}}, tok_in.m};
    xh    = (((eqm & pv) + pv) ^ pv) | eqm;
    ph    = mv | ~(xh | pv);
    mh    = pv & xh;
    p_out = ph[top_bit];
    m_out = mh[top_bit];
    phs   = {ph[WORD_BITS-2:0], tok_in.p};
    mhs   = {mh[WORD_BITS-2:0], tok_in.m};
    pv_next = mhs | ~(xv | phs);
    mv_next = phs & xv;
    evt.up   = tok_in.valid && is_last && p_out;
    evt.down = tok_in.valid && is_last && !p_out && m_out;
  end

  always_ff @(posedge clk) begin
    if (load_en) begin
      ref_sym[load_row] <= load_sym;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      pv      <= '1;
      mv      <= '0;
      tok_out <= '0;
    end else begin
      if (tok_in.valid) begin
        pv <= pv_next;
        mv <= mv_next;
      end
      // hand the carry on unless this block holds the last row
      tok_out.valid <= tok_in.valid && !is_last;
      tok_out.sym   <= tok_in.sym;
      tok_out.p     <= p_out;
      tok_out.m     <= m_out;
    end
  end

endmodule

### tb/bit_parallel_edit_distance_top_tb.sv
// Self-checking testbench for bit_parallel_edit_distance_top: random reference/word rounds
// checked against a bit-vector edit distance predictor. Depends on bped_pkg and the RTL.
module bit_parallel_edit_distance_top_tb;
  import bped_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int PATTERN_WORDS = 4;
  localparam int CAPACITY      = PATTERN_WORDS * WORD_BITS;
  localparam int HOLD_CYCLES   = 300;
  localparam int PHASE_BEATS   = 120;
  localparam int RUN_LIMIT_NS  = 2_000_000;
  // Mode encoding the block has no use for; it must be dropped silently.
  localparam logic [1:0] MODE_SPARE = 2'd3;

  typedef struct packed {
    logic [1:0]             op;
    logic [SYMBOL_BITS-1:0] sym;
  } beat_t;

  typedef struct packed {
    logic [SCORE_BITS-1:0] dist_value;
    logic                  overflow;
  } distance_result_t;

  logic                   clk;
  logic                   rst       = 1'b1;
  logic                   in_valid  = 1'b0;
  logic                   in_stall;
  logic [1:0]             mode      = MODE_LOAD;
  logic [SYMBOL_BITS-1:0] symbol    = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [SCORE_BITS-1:0]  distance;
  logic                   reference_overflow;

  bit_parallel_edit_distance_top #(
    .PATTERN_WORDS(PATTERN_WORDS)
  ) dut (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .mode              (mode),
    .symbol            (symbol),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .distance          (distance),
    .reference_overflow(reference_overflow)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Beats waiting to be offered, and distances waiting to come back.
  beat_t            pending_beats[$];
  distance_result_t expected_distances[$];
  int unsigned      queued_total = 0;
  int               mismatches   = 0;

  // Idling knobs, changed by the stimulus process between phases.
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  bit          pressure_on    = 1'b0;

  // ---------------------------------------------------------------------------
  // Predictor: multi-block bit-vector edit distance, one 64-row block at a time.
  // ---------------------------------------------------------------------------
  logic [SYMBOL_BITS-1:0] ref_store [CAPACITY];
  logic [WORD_BITS-1:0]   pos_vert  [PATTERN_WORDS];
  logic [WORD_BITS-1:0]   neg_vert  [PATTERN_WORDS];
  int unsigned            ref_len;
  int unsigned            row_score;
  bit                     word_open;
  bit                     ref_dropped;

  function automatic void clear_round();
    for (int b = 0; b < PATTERN_WORDS; b++) begin
      pos_vert[b] = '1;
      neg_vert[b] = '0;
    end
    ref_len     = 0;
    row_score   = 0;
    word_open   = 1'b0;
    ref_dropped = 1'b0;
  endfunction

  // Saturation is sticky: once at the top the score no longer moves down.
  function automatic void score_up();
    if (row_score < SCORE_MAX) row_score++;
  endfunction

  function automatic void score_down();
    if (row_score != SCORE_MAX && row_score > 0) row_score--;
  endfunction

  function automatic void apply_word_symbol(logic [SYMBOL_BITS-1:0] sym);
    int unsigned          last_blk;
    int unsigned          top;
    logic [WORD_BITS-1:0] pv, mv, eq, xv, xh, ph, mh;
    logic                 p_in, m_in, p_out, m_out;
    p_in = 1'b1;
    m_in = 1'b0;
    if (!word_open) begin
      word_open = 1'b1;
      row_score = (ref_len < SCORE_MAX) ? ref_len : SCORE_MAX;
    end
    // Empty reference: every word symbol is one insertion.
    if (ref_len == 0) begin
      score_up();
      return;
    end
    last_blk = (ref_len - 1) / WORD_BITS;
    for (int b = 0; b <= last_blk; b++) begin
      top = (b == last_blk) ? (ref_len - 1) % WORD_BITS : WORD_BITS - 1;
      pv  = pos_vert[b];
      mv  = neg_vert[b];
      eq  = '0;
      for (int i = 0; i <= top; i++)
        if (ref_store[b * WORD_BITS + i] == sym) eq[i] = 1'b1;
      xv    = eq | mv;
      eq[0] = eq[0] | m_in;
      xh    = (((eq & pv) + pv) ^ pv) | eq;
      ph    = mv | ~(xh | pv);
      mh    = pv & xh;
      p_out = ph[top];
      m_out = mh[top];
      if (b == last_blk) begin
        if (p_out) score_up();
        else if (m_out) score_down();
      end
      ph = {ph[WORD_BITS-2:0], p_in};
      mh = {mh[WORD_BITS-2:0], m_in};
      pos_vert[b] = mh | ~(xv | ph);
      neg_vert[b] = ph & xv;
      // Carry the horizontal delta into the next block.
      p_in = p_out;
      m_in = m_out;
    end
  endfunction

  function automatic void predict_beat(logic [1:0] op, logic [SYMBOL_BITS-1:0] sym);
    distance_result_t res;
    int unsigned      d;
    case (op)
      MODE_LOAD: begin
        // Loads after the word has started are dropped without a flag.
        if (!word_open) begin
          if (ref_len < CAPACITY) begin
            ref_store[ref_len] = sym;
            ref_len++;
          end else begin
            ref_dropped = 1'b1;
          end
        end
      end
      MODE_WORD: apply_word_symbol(sym);
      MODE_FINISH: begin
        d              = word_open ? row_score : ((ref_len < SCORE_MAX) ? ref_len : SCORE_MAX);
        res.dist_value = SCORE_BITS'(d);
        res.overflow   = ref_dropped;
        expected_distances.push_back(res);
        clear_round();
      end
      default: ;
    endcase
  endfunction

  initial clear_round();

  // ---------------------------------------------------------------------------
  // Driver: predict on every accepted beat, then offer the next one or idle.
  // ---------------------------------------------------------------------------
  beat_t next_beat;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) predict_beat(mode, symbol);
      // Hold a stalled beat; otherwise advance or go idle.
      if (!in_valid || !in_stall) begin
        if (pending_beats.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          next_beat = pending_beats.pop_front();
          in_valid  <= 1'b1;
          mode      <= next_beat.op;
          symbol    <= next_beat.sym;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, plus one long hold-off once pressure starts so the
  // result register fills and the block has to stall its input.
  // ---------------------------------------------------------------------------
  int unsigned hold_left;
  bit          hold_done;

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (pressure_on && !hold_done) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Monitor: compare each accepted result beat with the oldest expectation.
  distance_result_t want;

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_distances.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: distance %0d overflow %0b", distance,
                   reference_overflow);
      end else begin
        want = expected_distances.pop_front();
        if (distance !== want.dist_value || reference_overflow !== want.overflow) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected distance %0d overflow %0b, got distance %0d overflow %0b",
                     want.dist_value, want.overflow, distance, reference_overflow);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  function automatic void push_beat(logic [1:0] op, logic [SYMBOL_BITS-1:0] sym);
    beat_t bt;
    bt.op  = op;
    bt.sym = sym;
    pending_beats.push_back(bt);
    queued_total++;
  endfunction

  // One well-formed round: reference loads, word symbols, finish. Symbols come
  // from a tiny per-round alphabet so matches are common; the word mostly
  // copies the reference with random edits. Drop in noise now and then.
  function automatic void queue_round(int unsigned ref_n, int unsigned word_n);
    logic [SYMBOL_BITS-1:0] alphabet [4];
    logic [SYMBOL_BITS-1:0] ref_syms [$];
    logic [SYMBOL_BITS-1:0] s;
    int unsigned            alpha_n;
    int unsigned            spare_at;
    int unsigned            late_load_at;
    alpha_n = $urandom_range(1, 4);
    for (int k = 0; k < 4; k++) alphabet[k] = SYMBOL_BITS'($urandom);
    spare_at     = ($urandom_range(0, 9) == 0) ? $urandom_range(0, ref_n) : CAPACITY * 2;
    late_load_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, word_n) : CAPACITY * 2;
    for (int i = 0; i < ref_n; i++) begin
      s = ($urandom_range(0, 7) == 0) ? SYMBOL_BITS'($urandom)
                                      : alphabet[$urandom_range(0, alpha_n - 1)];
      ref_syms.push_back(s);
      push_beat(MODE_LOAD, s);
      if (i == spare_at) push_beat(MODE_SPARE, SYMBOL_BITS'($urandom));
    end
    for (int i = 0; i < word_n; i++) begin
      if (i < ref_syms.size() && $urandom_range(0, 2) != 0) s = ref_syms[i];
      else s = alphabet[$urandom_range(0, alpha_n - 1)];
      push_beat(MODE_WORD, s);
      if (i == late_load_at) push_beat(MODE_LOAD, SYMBOL_BITS'($urandom));
    end
    push_beat(MODE_FINISH, SYMBOL_BITS'($urandom));
  endfunction

  // Mostly short rounds; now and then a longer reference that can span several
  // blocks, or a long word.
  function automatic void queue_random_round();
    int unsigned pick;
    pick = $urandom_range(0, 15);
    queue_round((pick == 0) ? $urandom_range(40, 140) : $urandom_range(0, 12),
                (pick == 1) ? $urandom_range(30, 70) : $urandom_range(0, 14));
  endfunction

  // Wait until every beat is taken and every result is back.
  task automatic wait_drained();
    while (pending_beats.size() != 0 || in_valid || expected_distances.size() != 0)
      @(posedge clk);
  endtask

  int unsigned send_idle_by_phase [4] = '{0, 64, 0, 12};
  int unsigned recv_stall_by_phase[4] = '{0, 0, 64, 12};
  int unsigned phase_target;

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Finish with nothing loaded and no word.
    push_beat(MODE_FINISH, 16'h0000);
    // Empty reference: distance is the word length.
    push_beat(MODE_WORD, 16'h0000);
    push_beat(MODE_WORD, 16'hFFFF);
    push_beat(MODE_WORD, 16'h1234);
    push_beat(MODE_FINISH, 16'hFFFF);
    // Empty word: distance is the reference length.
    push_beat(MODE_LOAD, 16'hFFFF);
    push_beat(MODE_LOAD, 16'h0000);
    push_beat(MODE_FINISH, 16'h5A5A);
    // Mixed round with an unused mode and a load after the word started.
    push_beat(MODE_LOAD, 16'hFFFF);
    push_beat(MODE_LOAD, 16'h0000);
    push_beat(MODE_LOAD, 16'h8001);
    push_beat(MODE_SPARE, 16'h7FFE);
    push_beat(MODE_WORD, 16'h0000);
    push_beat(MODE_LOAD, 16'h5555);
    push_beat(MODE_WORD, 16'h8001);
    push_beat(MODE_WORD, 16'hAAAA);
    push_beat(MODE_FINISH, 16'h0000);
    // Exact match.
    push_beat(MODE_LOAD, 16'hAAAA);
    push_beat(MODE_WORD, 16'hAAAA);
    push_beat(MODE_FINISH, 16'h0001);
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  <= send_idle_by_phase[ph];
      recv_stall_pct <= recv_stall_by_phase[ph];
      // Overfill the store once: every block used, extra loads dropped.
      if (ph == 0) queue_round(CAPACITY + 2, 6);
      phase_target = queued_total + PHASE_BEATS;
      while (queued_total < phase_target) queue_random_round();
      wait_drained();
    end

    // Back-to-back short rounds against a receiver that holds off for a while.
    send_idle_pct  <= 0;
    recv_stall_pct <= 0;
    pressure_on    <= 1'b1;
    for (int r = 0; r < 10; r++) queue_round(2, 2);
    wait_drained();

    // Let any stray result surface before judging.
    repeat (32) @(posedge clk);
    if (mismatches == 0) begin
      $display("bit_parallel_edit_distance_top_tb passed");
    end else begin
      $display("bit_parallel_edit_distance_top_tb failed");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("bit_parallel_edit_distance_top_tb failed");
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/bped_pkg.sv
rtl/bped_cell.sv
rtl/bit_parallel_edit_distance_top.sv
tb/bit_parallel_edit_distance_top_tb.sv
